// ----- rtl/core/tsr_pkg.sv -----
`timescale 1ns / 1ps

package tsr_pkg;

  localparam int INDEX_BITS = 10;
  localparam int ENTRY_W    = INDEX_BITS + 1;
  localparam int TABLE_SIZE = (1 << INDEX_BITS) + 1;
  localparam int REQ_W      = 3;
  localparam int WORD_W     = ENTRY_W + 1;
  localparam int IN_DATA_W  = ((REQ_W + ENTRY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((1 + ENTRY_W + 7) / 8) * 8;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [REQ_W-1:0]   req_t;

  localparam req_t REQ_ADD    = 3'd0;
  localparam req_t REQ_REMOVE = 3'd1;
  localparam req_t REQ_PICK   = 3'd2;
  localparam req_t REQ_MEMBER = 3'd3;
  localparam req_t REQ_EMPTY  = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ENT_CHK,
    ST_WALK_A,
    ST_WALK_AD,
    ST_WALK_BD,
    ST_WALK_OK,
    ST_WALK_FAIL,
    ST_ADD_LINK,
    ST_ADD_POS,
    ST_ADD_SOLO,
    ST_RESP
  } ctl_state_t;

  typedef enum logic [1:0] {
    RD_ENT,
    RD_A,
    RD_LINK
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_CLEAR,
    WR_TOMB,
    WR_SKIP,
    WR_LINK_S,
    WR_LINK_POS,
    WR_SOLO
  } wr_sel_t;

  typedef struct packed {
    logic    load_req;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    clr_inc;
    logic    walk_start;
    logic    walk_step;
    logic    b_load;
    logic    found_a;
    logic    found_b;
    logic    cur_clear;
    logic    cur_set_ent;
    logic    cur_set_next;
    logic    res_load;
    logic    res_flag;
    logic    res_pick;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    req_t req;
    logic ent_valid;
    logic cur_zero;
    logic a_valid;
    logic link_ok;
    logic rd_tomb;
    logic rd_link_zero;
    logic steps_last;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic idx_valid(entry_t x);
    return (x != '0) && (x <= ENTRY_W'(TABLE_SIZE - 1));
  endfunction

endpackage

// ----- rtl/core/tombstone_ring_set.sv -----
`timescale 1ns / 1ps

// Work set kept as a circular list of entries 1..1024 with lazy removal.
// Input channel in_*: one request item per handshake (add, remove, pick,
// membership query, emptiness query) with an entry number.
// Output channel out_*: exactly one result item per request, in order.
// After reset the link table is swept clear, one entry a cycle, through all
// 1025 words; in_tready stays low until the sweep is done.
// One request at a time: in_tready is high only while the block is idle.
// Remove and membership read the entry in the table, then give their result;
// no new item is taken before the block is back in idle. Invalid entries,
// unknown requests and queries on an empty set give their result unworked.
// Pick, emptiness and add walk the ring through the table memory, skipping
// one pair of tombstones per step until the walk ends on a live entry
// (add also does the entry check before the walk and the relinking after).
// Walks stop after at most 1026 steps. The result sits in an output register;
// while out_tready is low it holds, the next item is still accepted and
// worked, and its result waits until the held one is taken.
module tombstone_ring_set (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tsr_pkg::IN_DATA_W-1:0]  in_tdata,   // req_type[2:0], entry_index[13:3]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tsr_pkg::OUT_DATA_W-1:0] out_tdata   // result_flag[0], picked_index[11:1]
);

  tsr_pkg::ctl_cmd_t cmd;
  tsr_pkg::dp_sts_t  sts;

  tsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/core/tsr_ram.sv -----
`timescale 1ns / 1ps

module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tsr_ctrl.sv -----
`timescale 1ns / 1ps

module tsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tsr_pkg::dp_sts_t  sts,
  output tsr_pkg::ctl_cmd_t cmd
);

  tsr_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsr_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsr_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = tsr_pkg::ST_IDLE;
      end
      tsr_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = tsr_pkg::ST_DISPATCH;
      end
      tsr_pkg::ST_DISPATCH: begin
        if (sts.req == tsr_pkg::REQ_ADD || sts.req == tsr_pkg::REQ_REMOVE ||
            sts.req == tsr_pkg::REQ_MEMBER) begin
          state_nxt = sts.ent_valid ? tsr_pkg::ST_ENT_CHK : tsr_pkg::ST_RESP;
        end else if (sts.req == tsr_pkg::REQ_PICK || sts.req == tsr_pkg::REQ_EMPTY) begin
          state_nxt = sts.cur_zero ? tsr_pkg::ST_RESP : tsr_pkg::ST_WALK_A;
        end else begin
          state_nxt = tsr_pkg::ST_RESP;
        end
      end
      tsr_pkg::ST_ENT_CHK: begin
        if (sts.req != tsr_pkg::REQ_ADD || !sts.rd_link_zero || sts.rd_tomb) begin
          state_nxt = tsr_pkg::ST_RESP;
        end else if (sts.cur_zero) begin
          state_nxt = tsr_pkg::ST_ADD_SOLO;
        end else begin
          state_nxt = tsr_pkg::ST_WALK_A;
        end
      end
      tsr_pkg::ST_WALK_A: begin
        state_nxt = sts.a_valid ? tsr_pkg::ST_WALK_AD : tsr_pkg::ST_WALK_FAIL;
      end
      tsr_pkg::ST_WALK_AD: begin
        if (!sts.rd_tomb) state_nxt = tsr_pkg::ST_WALK_OK;
        else if (!sts.link_ok) state_nxt = tsr_pkg::ST_WALK_FAIL;
        else state_nxt = tsr_pkg::ST_WALK_BD;
      end
      tsr_pkg::ST_WALK_BD: begin
        if (!sts.rd_tomb) state_nxt = tsr_pkg::ST_WALK_OK;
        else if (!sts.link_ok || sts.steps_last) state_nxt = tsr_pkg::ST_WALK_FAIL;
        else state_nxt = tsr_pkg::ST_WALK_A;
      end
      tsr_pkg::ST_WALK_OK: begin
        state_nxt = (sts.req == tsr_pkg::REQ_ADD) ? tsr_pkg::ST_ADD_LINK : tsr_pkg::ST_RESP;
      end
      tsr_pkg::ST_WALK_FAIL: begin
        state_nxt = (sts.req == tsr_pkg::REQ_ADD) ? tsr_pkg::ST_ADD_SOLO : tsr_pkg::ST_RESP;
      end
      tsr_pkg::ST_ADD_LINK: state_nxt = tsr_pkg::ST_ADD_POS;
      tsr_pkg::ST_ADD_POS:  state_nxt = tsr_pkg::ST_RESP;
      tsr_pkg::ST_ADD_SOLO: state_nxt = tsr_pkg::ST_RESP;
      tsr_pkg::ST_RESP: begin
        if (sts.out_free) state_nxt = tsr_pkg::ST_IDLE;
      end
      default: state_nxt = tsr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tsr_pkg::ST_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = tsr_pkg::WR_CLEAR;
        cmd.clr_inc = 1'b1;
      end
      tsr_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      tsr_pkg::ST_DISPATCH: begin
        cmd.rd_sel     = tsr_pkg::RD_ENT;
        cmd.walk_start = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_flag   = (sts.req == tsr_pkg::REQ_EMPTY) && sts.cur_zero;
      end
      tsr_pkg::ST_ENT_CHK: begin
        cmd.walk_start = 1'b1;
        cmd.res_load   = 1'b1;
        if (sts.req == tsr_pkg::REQ_REMOVE) begin
          cmd.res_flag = !sts.rd_tomb;
          cmd.wr_en    = !sts.rd_tomb;
          cmd.wr_sel   = tsr_pkg::WR_TOMB;
        end else if (sts.req == tsr_pkg::REQ_MEMBER) begin
          cmd.res_flag = !sts.rd_link_zero;
        end
      end
      tsr_pkg::ST_WALK_A: begin
        cmd.rd_sel = tsr_pkg::RD_A;
      end
      tsr_pkg::ST_WALK_AD: begin
        if (!sts.rd_tomb) begin
          cmd.found_a = 1'b1;
        end else begin
          cmd.b_load = 1'b1;
          cmd.rd_sel = tsr_pkg::RD_LINK;
        end
      end
      tsr_pkg::ST_WALK_BD: begin
        if (!sts.rd_tomb) begin
          cmd.found_b = 1'b1;
        end else if (sts.link_ok) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = tsr_pkg::WR_SKIP;
          cmd.walk_step = 1'b1;
        end
      end
      tsr_pkg::ST_WALK_OK: begin
        if (sts.req == tsr_pkg::REQ_PICK) begin
          cmd.res_load     = 1'b1;
          cmd.res_flag     = 1'b1;
          cmd.res_pick     = 1'b1;
          cmd.cur_set_next = 1'b1;
        end
      end
      tsr_pkg::ST_WALK_FAIL: begin
        cmd.cur_clear = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_flag  = (sts.req == tsr_pkg::REQ_EMPTY);
      end
      tsr_pkg::ST_ADD_LINK: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = tsr_pkg::WR_LINK_S;
      end
      tsr_pkg::ST_ADD_POS: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = tsr_pkg::WR_LINK_POS;
        cmd.res_load = 1'b1;
        cmd.res_flag = 1'b1;
      end
      tsr_pkg::ST_ADD_SOLO: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = tsr_pkg::WR_SOLO;
        cmd.cur_set_ent = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_flag    = 1'b1;
      end
      tsr_pkg::ST_RESP: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/tsr_dpath.sv -----
`timescale 1ns / 1ps

module tsr_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tsr_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tsr_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  tsr_pkg::ctl_cmd_t                cmd,
  output tsr_pkg::dp_sts_t                 sts
);

  tsr_pkg::req_t   req_r;
  tsr_pkg::entry_t ent_r;
  tsr_pkg::entry_t cur_r;
  tsr_pkg::entry_t a_r;
  tsr_pkg::entry_t b_r;
  tsr_pkg::entry_t found_r;
  tsr_pkg::entry_t flink_r;
  tsr_pkg::entry_t steps_r;
  tsr_pkg::entry_t clr_r;
  logic            res_flag_r;
  tsr_pkg::entry_t res_pick_r;
  logic            out_valid_r;
  logic            out_flag_r;
  tsr_pkg::entry_t out_pick_r;

  tsr_pkg::entry_t              raddr;
  tsr_pkg::entry_t              waddr;
  logic [tsr_pkg::WORD_W-1:0]   wdata;
  logic [tsr_pkg::WORD_W-1:0]   rdata;
  logic                         rd_tomb;
  tsr_pkg::entry_t              rd_link;

  assign rd_tomb = rdata[tsr_pkg::ENTRY_W];
  assign rd_link = rdata[tsr_pkg::ENTRY_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      tsr_pkg::RD_A:    raddr = a_r;
      tsr_pkg::RD_LINK: raddr = rd_link;
      default:          raddr = ent_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      tsr_pkg::WR_TOMB: begin
        waddr = ent_r;
        wdata = {1'b1, rd_link};
      end
      tsr_pkg::WR_SKIP: begin
        waddr = a_r;
        wdata = {1'b1, rd_link};
      end
      tsr_pkg::WR_LINK_S: begin
        waddr = ent_r;
        wdata = {1'b0, flink_r};
      end
      tsr_pkg::WR_LINK_POS: begin
        waddr = found_r;
        wdata = {1'b0, ent_r};
      end
      tsr_pkg::WR_SOLO: begin
        waddr = ent_r;
        wdata = {1'b0, ent_r};
      end
      default: begin
        waddr = clr_r;
        wdata = '0;
      end
    endcase
  end

  tsr_ram #(
    .WIDTH(tsr_pkg::WORD_W),
    .DEPTH(tsr_pkg::TABLE_SIZE)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_inc) clr_r <= clr_r + 1'b1;
      if (cmd.cur_set_ent) begin
        cur_r <= ent_r;
      end else if (cmd.cur_set_next && flink_r != '0) begin
        cur_r <= flink_r;
      end else if (cmd.cur_clear) begin
        cur_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_tdata[tsr_pkg::REQ_W-1:0];
      ent_r <= in_tdata[tsr_pkg::REQ_W +: tsr_pkg::ENTRY_W];
    end
    if (cmd.walk_start) begin
      a_r     <= cur_r;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      a_r     <= rd_link;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.b_load) b_r <= rd_link;
    if (cmd.found_a) begin
      found_r <= a_r;
      flink_r <= rd_link;
    end else if (cmd.found_b) begin
      found_r <= b_r;
      flink_r <= rd_link;
    end
    if (cmd.res_load) begin
      res_flag_r <= cmd.res_flag;
      res_pick_r <= cmd.res_pick ? found_r : '0;
    end
    if (cmd.out_load) begin
      out_flag_r <= res_flag_r;
      out_pick_r <= res_pick_r;
    end
  end

  assign sts.req          = req_r;
  assign sts.ent_valid    = tsr_pkg::idx_valid(ent_r);
  assign sts.cur_zero     = (cur_r == '0);
  assign sts.a_valid      = tsr_pkg::idx_valid(a_r);
  assign sts.link_ok      = tsr_pkg::idx_valid(rd_link) && (rd_link != a_r);
  assign sts.rd_tomb      = rd_tomb;
  assign sts.rd_link_zero = (rd_link == '0);
  assign sts.steps_last   = (steps_r == tsr_pkg::ENTRY_W'(tsr_pkg::TABLE_SIZE));
  assign sts.clr_last     = (clr_r == tsr_pkg::ENTRY_W'(tsr_pkg::TABLE_SIZE - 1));
  assign sts.out_free     = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tsr_pkg::OUT_DATA_W - tsr_pkg::ENTRY_W - 1){1'b0}},
                       out_pick_r, out_flag_r};

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tsr_pkg::*;

  localparam req_t REQ_BAD_FIRST = 3'd5;
  localparam req_t REQ_BAD_LAST  = 3'd7;
  localparam int   DIR_ROWS      = 27;

  typedef struct packed {
    req_t   rq;
    entry_t en;
    logic   fixed;
    logic   flag;
    entry_t pick;
  } dir_row_t;

  typedef struct {
    bit     flag;
    entry_t pick;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  entry_t   ring_next [0:TABLE_SIZE-1] = '{default: '0};
  bit       tombed    [0:TABLE_SIZE-1] = '{default: 1'b0};
  entry_t   ring_head = '0;
  verdict_t owed_results [$];
  entry_t   added_entries [$];
  int       fails = 0;
  int       sent = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{REQ_EMPTY,     11'd0,    1'b1, 1'b1, 11'd0},
    '{REQ_PICK,      11'd0,    1'b1, 1'b0, 11'd0},
    '{REQ_MEMBER,    11'd5,    1'b1, 1'b0, 11'd0},
    '{REQ_ADD,       11'd0,    1'b1, 1'b0, 11'd0},
    '{REQ_ADD,       11'd1025, 1'b1, 1'b0, 11'd0},
    '{REQ_ADD,       11'd2047, 1'b1, 1'b0, 11'd0},
    '{REQ_REMOVE,    11'd0,    1'b1, 1'b0, 11'd0},
    '{REQ_ADD,       11'd1,    1'b1, 1'b1, 11'd0},
    '{REQ_ADD,       11'd1,    1'b1, 1'b0, 11'd0},
    '{REQ_ADD,       11'd1024, 1'b1, 1'b1, 11'd0},
    '{REQ_ADD,       11'd7,    1'b0, 1'b0, 11'd0},
    '{REQ_MEMBER,    11'd1024, 1'b1, 1'b1, 11'd0},
    '{REQ_PICK,      11'd0,    1'b0, 1'b0, 11'd0},
    '{REQ_REMOVE,    11'd9,    1'b1, 1'b1, 11'd0},
    '{REQ_ADD,       11'd9,    1'b1, 1'b0, 11'd0},
    '{REQ_REMOVE,    11'd9,    1'b1, 1'b0, 11'd0},
    '{REQ_REMOVE,    11'd1,    1'b1, 1'b1, 11'd0},
    '{REQ_REMOVE,    11'd1024, 1'b1, 1'b1, 11'd0},
    '{REQ_REMOVE,    11'd7,    1'b1, 1'b1, 11'd0},
    '{REQ_PICK,      11'd0,    1'b0, 1'b0, 11'd0},
    '{REQ_EMPTY,     11'd0,    1'b0, 1'b0, 11'd0},
    '{REQ_ADD,       11'd3,    1'b0, 1'b0, 11'd0},
    '{REQ_MEMBER,    11'd1,    1'b1, 1'b1, 11'd0},
    '{REQ_PICK,      11'd2047, 1'b0, 1'b0, 11'd0},
    '{REQ_BAD_FIRST, 11'd3,    1'b1, 1'b0, 11'd0},
    '{REQ_BAD_LAST,  11'd2047, 1'b1, 1'b0, 11'd0},
    '{REQ_REMOVE,    11'd1025, 1'b1, 1'b0, 11'd0}
  };

  tombstone_ring_set dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit in_table(entry_t e);
    return (e != '0) && (int'(e) < TABLE_SIZE);
  endfunction

  // walk to a live entry, short-cutting tombstone pairs; clear head on failure
  function automatic bit find_live(entry_t start, output entry_t hit);
    entry_t a;
    entry_t b;
    entry_t c;
    a = start;
    hit = '0;
    for (int steps = 0; steps <= TABLE_SIZE; steps++) begin
      if (!in_table(a)) break;
      if (!tombed[a]) begin
        hit = a;
        return 1'b1;
      end
      b = ring_next[a];
      if (!in_table(b) || b == a) break;
      if (!tombed[b]) begin
        hit = b;
        return 1'b1;
      end
      c = ring_next[b];
      if (!in_table(c) || c == a) break;
      ring_next[a] = c;
      a = c;
    end
    ring_head = '0;
    return 1'b0;
  endfunction

  function automatic verdict_t serve_request(req_t rq, entry_t en);
    verdict_t v;
    entry_t hit;
    v.flag = 1'b0;
    v.pick = '0;
    case (rq)
      REQ_ADD: begin
        if (in_table(en) && ring_next[en] == '0 && !tombed[en]) begin
          v.flag = 1'b1;
          if (ring_head != '0 && find_live(ring_head, hit)) begin
            ring_next[en] = ring_next[hit];
            ring_next[hit] = en;
          end else begin
            ring_next[en] = en;
            ring_head = en;
          end
        end
      end
      REQ_REMOVE: begin
        if (in_table(en) && !tombed[en]) begin
          tombed[en] = 1'b1;
          v.flag = 1'b1;
        end
      end
      REQ_PICK: begin
        if (ring_head != '0 && find_live(ring_head, hit)) begin
          v.flag = 1'b1;
          v.pick = hit;
          if (ring_next[hit] != '0) ring_head = ring_next[hit];
        end
      end
      REQ_MEMBER: begin
        v.flag = in_table(en) && ring_next[en] != '0;
      end
      REQ_EMPTY: begin
        if (ring_head == '0) v.flag = 1'b1;
        else v.flag = !find_live(ring_head, hit);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic entry_t choose_entry(int pct_known);
    int r;
    r = $urandom_range(0, 99);
    if (r < pct_known && added_entries.size() > 0)
      return added_entries[$urandom_range(0, added_entries.size() - 1)];
    if (r < 94) return entry_t'($urandom_range(1, 1024));
    return entry_t'($urandom_range(0, 2047));
  endfunction

  task automatic send_item(req_t rq, entry_t en, bit fixed, bit fx_flag, entry_t fx_pick);
    int gap;
    verdict_t v;
    gap = (((sent / 40) % 4) == 2) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({en, rq});
    do @(posedge clk); while (in_tready !== 1'b1);
    sent++;
    v = serve_request(rq, en);
    if (rq == REQ_ADD && v.flag) added_entries.push_back(en);
    if (fixed) begin
      v.flag = fx_flag;
      v.pick = fx_pick;
    end
    owed_results.push_back(v);
  endtask

  initial begin
    int taken;
    int stall;
    verdict_t want;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = (((taken / 40) % 4) == 1) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      taken++;
      if (owed_results.size() == 0) begin
        $error("unexpected result item: out_tdata=%h", out_tdata);
        fails++;
      end else begin
        want = owed_results.pop_front();
        if (out_tdata[0] !== want.flag) begin
          $error("result_flag: expected %0d, actual %0d", want.flag, out_tdata[0]);
          fails++;
        end
        if (out_tdata[ENTRY_W:1] !== want.pick) begin
          $error("picked_index: expected %0d, actual %0d", want.pick, out_tdata[ENTRY_W:1]);
          fails++;
        end
      end
    end
  end

  initial begin
    int r;
    int ta;
    int tr;
    int tp;
    int tm;
    int te;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_tab[i].rq, dir_tab[i].en, dir_tab[i].fixed, dir_tab[i].flag,
                dir_tab[i].pick);

    // grow, mix and drain the ring in turn
    for (int i = 0; i < 700; i++) begin
      case ((i / 70) % 3)
        0:       begin ta = 45; tr = 55; tp = 75; tm = 85; te = 95; end
        1:       begin ta = 20; tr = 45; tp = 75; tm = 85; te = 95; end
        default: begin ta = 8;  tr = 53; tp = 80; tm = 88; te = 96; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ta)      send_item(REQ_ADD, choose_entry(10), 1'b0, 1'b0, '0);
      else if (r < tr) send_item(REQ_REMOVE, choose_entry(80), 1'b0, 1'b0, '0);
      else if (r < tp) send_item(REQ_PICK, entry_t'($urandom_range(0, 2047)), 1'b0, 1'b0, '0);
      else if (r < tm) send_item(REQ_MEMBER, choose_entry(50), 1'b0, 1'b0, '0);
      else if (r < te) send_item(REQ_EMPTY, entry_t'($urandom_range(0, 2047)), 1'b0, 1'b0, '0);
      else send_item(req_t'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)),
                     entry_t'($urandom_range(0, 2047)), 1'b0, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("tombstone_ring_set verification clean");
    end else begin
      $display("tombstone_ring_set verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tombstone_ring_set verification failed");
    $finish;
  end

endmodule
